@@ hdl/aho_corasick_automaton_builder_unit_assert.svh @@
// Assertion macros for the automaton builder
`ifndef AHO_CORASICK_AUTOMATON_BUILDER_UNIT_ASSERT_SVH
`define AHO_CORASICK_AUTOMATON_BUILDER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ACB_ASSERT_IMPL(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ACB_ASSERT_NEXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ACB_ASSERT_IMPL(label, a, c, msg)
`define ACB_ASSERT_NEXT(label, a, c, msg)
`endif
`endif

@@ hdl/acb_pkg.sv @@
// Shared types and codes for the automaton builder
`timescale 1ns / 1ps
`default_nettype none
package acb_pkg;
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_BUILD  = 2'd2;
  localparam logic [1:0] FUNC_READ   = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [4:0] symbol;
    logic       pattern_end;
    logic [7:0] pattern_id;
    logic [8:0] node;
  } acb_in_t;

  typedef struct packed {
    logic [8:0] next_node;
    logic [8:0] fail_node;
    logic [7:0] match_id;
    logic [8:0] node_count;
    logic       status;
  } acb_out_t;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLR_ROOT, CMD_INS_RD, CMD_INS_WR, CMD_RD_RD, CMD_RD_OUT,
    CMD_B_INIT, CMD_B_RD, CMD_B_WR, CMD_B_POP, CMD_B_POPRD, CMD_DONE_OUT,
    CMD_ROW_CLR
  } acb_cmd_t;

  typedef struct packed {
    logic sym_last;
    logic queue_empty;
    logic row_last;
    logic node_new;
  } acb_stat_t;
endpackage
`default_nettype wire

@@ hdl/acb_datapath.sv @@
// Datapath: goto, fail, match and queue memories with build scan registers
`timescale 1ns / 1ps
`default_nettype none
module acb_datapath #(
  parameter int MAX_NODES = 512,
  parameter int ALPHABET  = 27
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire acb_pkg::acb_cmd_t cmd,
  input  wire acb_pkg::acb_in_t  item,
  output acb_pkg::acb_stat_t   stat,
  output acb_pkg::acb_out_t    result
);
  import acb_pkg::*;
  localparam int NW = $clog2(MAX_NODES);
  localparam int SW = $clog2(ALPHABET);
  localparam int AW = $clog2(MAX_NODES * ALPHABET);
  localparam int QW = NW + 1;

  logic [8:0] goto_mem [MAX_NODES * ALPHABET];
  logic [8:0] fail_mem [MAX_NODES];
  logic [7:0] match_mem [MAX_NODES];
  logic [8:0] queue_mem [MAX_NODES];

  logic [NW-1:0] used_r, used_nxt;
  logic [NW-1:0] cur_r, cur_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [NW-1:0] p_r, p_nxt, fp_r, fp_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          root_r, root_nxt;
  logic [8:0]    g_rd_r, gf_rd_r, f_rd_r, q_rd_r;
  logic [7:0]    m_rd_r;
  logic          st_r, st_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [SW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] new_node;

  logic          sym_ok;
  logic [AW-1:0] ga_a, ga_b;
  logic          g_we;
  logic [AW-1:0] g_wa;
  logic [8:0]    g_wd;
  logic          f_we, m_we, q_we;
  logic [NW-1:0] f_wa, m_wa;
  logic [8:0]    f_wd;
  logic [7:0]    m_wd;

  function automatic logic [AW-1:0] gaddr(input logic [NW-1:0] n, input logic [SW-1:0] s);
    logic [AW+NW-1:0] t;
    t = (AW+NW)'(n) * (AW+NW)'(ALPHABET) + (AW+NW)'(s);
    return t[AW-1:0];
  endfunction

  assign sym_ok = 32'(item.symbol) < ALPHABET;
  assign new_node = used_r + NW'(1);

  always_comb begin
    ga_a = '0;
    ga_b = gaddr(fp_r, s_r);
    unique case (cmd)
      CMD_INS_RD: ga_a = gaddr(cur_r, item.symbol[SW-1:0]);
      CMD_RD_RD:  ga_a = gaddr(item.node[NW-1:0], item.symbol[SW-1:0]);
      CMD_B_RD:   ga_a = root_r ? gaddr('0, s_r) : gaddr(p_r, s_r);
      default:    ga_a = '0;
    endcase
  end

  always_comb begin
    used_nxt = used_r; cur_nxt = cur_r; s_nxt = s_r; p_nxt = p_r; fp_nxt = fp_r;
    head_nxt = head_r; tail_nxt = tail_r; root_nxt = root_r; st_nxt = st_r;
    rd_ok_nxt = rd_ok_r; clr_nxt = clr_r;
    g_we = 1'b0; g_wa = '0; g_wd = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0;
    m_we = 1'b0; m_wa = '0; m_wd = '0;
    q_we = 1'b0;
    unique case (cmd)
      CMD_CLR_ROOT: begin
        used_nxt = '0; cur_nxt = '0; clr_nxt = '0; st_nxt = 1'b0;
        f_we = 1'b1; m_we = 1'b1;
      end
      CMD_ROW_CLR: begin
        // clears one goto entry of row used_r (new row or root)
        g_we = 1'b1; g_wa = gaddr(used_r, clr_r); clr_nxt = clr_r + SW'(1);
      end
      CMD_INS_RD: st_nxt = 1'b0;
      CMD_INS_WR: begin
        if (!sym_ok) begin
          st_nxt = 1'b0;
        end else if (g_rd_r == '0) begin
          if (32'(used_r) + 1 >= MAX_NODES) begin
            st_nxt = 1'b1;
            if (item.pattern_end) cur_nxt = '0;
          end else begin
            used_nxt = new_node; clr_nxt = '0;
            g_we = 1'b1; g_wa = gaddr(cur_r, item.symbol[SW-1:0]); g_wd = 9'(new_node);
            f_we = 1'b1; f_wa = new_node;
            m_we = 1'b1; m_wa = new_node;
            if (item.pattern_end) begin
              m_wd = item.pattern_id; cur_nxt = '0;
            end else begin
              cur_nxt = new_node;
            end
          end
        end else begin
          if (item.pattern_end) begin
            m_we = 1'b1; m_wa = g_rd_r[NW-1:0]; m_wd = item.pattern_id; cur_nxt = '0;
          end else begin
            cur_nxt = g_rd_r[NW-1:0];
          end
        end
      end
      CMD_RD_RD: begin
        rd_ok_nxt = (32'(item.node) <= 32'(used_r)) && (32'(item.node) < MAX_NODES);
        st_nxt = 1'b0;
      end
      CMD_B_INIT: begin
        head_nxt = '0; tail_nxt = '0; s_nxt = '0; root_nxt = 1'b1; st_nxt = 1'b0;
      end
      CMD_B_WR: begin
        if (root_r) begin
          if (g_rd_r != '0 && 32'(g_rd_r) < MAX_NODES) begin
            f_we = 1'b1; f_wa = g_rd_r[NW-1:0];
            if (32'(tail_r) < MAX_NODES) begin
              q_we = 1'b1; tail_nxt = tail_r + QW'(1);
            end
          end
        end else if (g_rd_r != '0) begin
          if (32'(g_rd_r) < MAX_NODES) begin
            f_we = 1'b1; f_wa = g_rd_r[NW-1:0]; f_wd = gf_rd_r;
            if (32'(tail_r) < MAX_NODES) begin
              q_we = 1'b1; tail_nxt = tail_r + QW'(1);
            end
          end
        end else begin
          g_we = 1'b1; g_wa = gaddr(p_r, s_r); g_wd = gf_rd_r;
        end
        s_nxt = stat.sym_last ? '0 : s_r + SW'(1);
        if (stat.sym_last) root_nxt = 1'b0;
      end
      CMD_B_POP: head_nxt = head_r + QW'(1);
      CMD_B_POPRD: begin
        p_nxt = q_rd_r[NW-1:0]; fp_nxt = f_rd_r[NW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0; cur_r <= '0; s_r <= '0; head_r <= '0; tail_r <= '0;
      root_r <= 1'b0; st_r <= 1'b0; rd_ok_r <= 1'b0; clr_r <= '0;
    end else begin
      used_r <= used_nxt; cur_r <= cur_nxt; s_r <= s_nxt; head_r <= head_nxt;
      tail_r <= tail_nxt; root_r <= root_nxt; st_r <= st_nxt; rd_ok_r <= rd_ok_nxt;
      clr_r <= clr_nxt;
    end
    p_r <= p_nxt; fp_r <= fp_nxt;
  end

  // fail lookup during a pop addresses fail_mem with the registered queue output q_rd_r
  always_ff @(posedge clk) begin
    if (g_we) goto_mem[g_wa] <= g_wd;
    g_rd_r  <= goto_mem[ga_a];
    gf_rd_r <= goto_mem[ga_b];
  end

  always_ff @(posedge clk) begin
    if (f_we) fail_mem[f_wa] <= f_wd;
    f_rd_r <= (cmd == CMD_RD_RD) ? fail_mem[item.node[NW-1:0]] : fail_mem[q_rd_r[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (m_we) match_mem[m_wa] <= m_wd;
    m_rd_r <= match_mem[item.node[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (q_we) queue_mem[tail_r[NW-1:0]] <= g_rd_r;
    q_rd_r <= queue_mem[head_r[NW-1:0]];
  end

  assign stat.sym_last    = 32'(s_r) == ALPHABET - 1;
  assign stat.queue_empty = head_r == tail_r;
  assign stat.row_last    = 32'(clr_r) == ALPHABET - 1;
  assign stat.node_new    = sym_ok && (g_rd_r == '0) && (32'(used_r) + 1 < MAX_NODES);

  always_comb begin
    result = '0;
    result.node_count = 9'(used_r);
    result.status = st_r;
    if (cmd == CMD_RD_OUT && rd_ok_r) begin
      result.next_node = sym_ok ? g_rd_r : '0;
      result.fail_node = f_rd_r;
      result.match_id  = m_rd_r;
    end
  end
endmodule
`default_nettype wire

@@ hdl/acb_ctrl.sv @@
// Controller state machine sequencing the datapath commands
`timescale 1ns / 1ps
`default_nettype none
module acb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire acb_pkg::acb_in_t  item_r,
  output logic                   item_load,
  input  wire acb_pkg::acb_stat_t stat,
  output acb_pkg::acb_cmd_t      cmd,
  output logic                   out_load,
  input  wire logic              out_free
);
  import acb_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_CLR = 4'd2, S_INIT = 4'd3,
    S_INSWR = 4'd4, S_RSTCLR = 4'd5, S_RDOUT = 4'd6, S_BRD = 4'd8,
    S_BWR = 4'd9, S_POP = 4'd10, S_POP2 = 4'd11, S_POP3 = 4'd12, S_DONE = 4'd13,
    S_INSCLR = 4'd14;
  logic [3:0] st_r, st_nxt;

  always_comb begin
    st_nxt = st_r; cmd = CMD_NONE; item_load = 1'b0; out_load = 1'b0;
    in_stall = 1'b1;
    unique case (st_r)
      S_INIT: begin cmd = CMD_CLR_ROOT; st_nxt = S_RSTCLR; end
      S_RSTCLR: begin
        cmd = CMD_ROW_CLR;
        if (stat.row_last) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_load = 1'b1; st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (item_r.func)
          FUNC_CLEAR:  begin cmd = CMD_CLR_ROOT; st_nxt = S_CLR; end
          FUNC_INSERT: begin cmd = CMD_INS_RD; st_nxt = S_INSWR; end
          FUNC_BUILD:  begin cmd = CMD_B_INIT; st_nxt = S_BRD; end
          default:     begin cmd = CMD_RD_RD; st_nxt = S_RDOUT; end
        endcase
      end
      S_CLR: begin
        cmd = CMD_ROW_CLR;
        if (stat.row_last) st_nxt = S_DONE;
      end
      S_INSWR: begin
        cmd = CMD_INS_WR;
        st_nxt = stat.node_new ? S_INSCLR : S_DONE;
      end
      S_INSCLR: begin
        cmd = CMD_ROW_CLR;
        if (stat.row_last) st_nxt = S_DONE;
      end
      S_RDOUT: if (out_free) begin
        cmd = CMD_RD_OUT; out_load = 1'b1; st_nxt = S_IDLE;
      end else begin
        cmd = CMD_RD_RD;
      end
      S_BRD: begin cmd = CMD_B_RD; st_nxt = S_BWR; end
      S_BWR: begin
        cmd = CMD_B_WR;
        st_nxt = stat.sym_last ? S_POP : S_BRD;
      end
      S_POP: begin
        if (stat.queue_empty) st_nxt = S_DONE;
        else st_nxt = S_POP2;
      end
      S_POP2: begin cmd = CMD_B_POP; st_nxt = S_POP3; end
      S_POP3: begin cmd = CMD_B_POPRD; st_nxt = S_BRD; end
      S_DONE: if (out_free) begin
        cmd = CMD_DONE_OUT; out_load = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_INIT;
    else st_r <= st_nxt;
  end
endmodule
`default_nettype wire

@@ hdl/aho_corasick_automaton_builder_unit.sv @@
// Top level of the Aho-Corasick automaton builder
`timescale 1ns / 1ps
`default_nettype none
// One command per transfer, one result per command. When an insert adds a node,
// the new node's goto row is cleared one entry a cycle through the single goto
// write port. Build walks the root and every queued node times ALPHABET, with a
// goto memory read then write per entry and a queue pop per node. Input is
// stalled until the result moves into the output register. After reset the root
// entries are cleared with input stalled; other rows are cleared when their node
// is created.
`include "aho_corasick_automaton_builder_unit_assert.svh"
module aho_corasick_automaton_builder_unit #(
  parameter int MAX_NODES = 512,
  parameter int ALPHABET  = 27
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire acb_pkg::acb_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output acb_pkg::acb_out_t     out_data
);
  import acb_pkg::*;
  acb_in_t   item_r;
  acb_cmd_t  cmd;
  acb_stat_t stat;
  acb_out_t  res;
  logic item_load, out_load, out_free, out_valid_r;

  always_ff @(posedge clk) if (item_load) item_r <= in_data;

  assign out_free = !out_valid_r || !out_stall;

  acb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .item_r, .item_load, .stat, .cmd,
    .out_load, .out_free
  );

  acb_datapath #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET)) u_dp (
    .clk, .rst_n, .cmd, .item(item_r), .stat, .result(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) if (out_load) out_data <= res;
  assign out_valid = out_valid_r;

  `ACB_ASSERT_IMPL(a_load_free, out_load, !out_valid_r || !out_stall, "result overwritten")
  `ACB_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall, "accepted while busy")
  `ACB_ASSERT_IMPL(a_no_both, item_load, !out_load, "load and output together")
endmodule
`default_nettype wire
